// ===== src/pts_pkg.sv =====
// Shared types and codes for the print and tone spooler.
package pts_pkg;

  // Item opcodes
  localparam logic [1:0] OP_TEXT = 2'd0;
  localparam logic [1:0] OP_TONE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Message writer modes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_WRITING  = 2'd1;
  localparam logic [1:0] MODE_DROPPING = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  text_char;
    logic [15:0] tone_frequency;
    logic [15:0] tone_duration_ms;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        tone_play;
    logic [15:0] play_frequency;
    logic [15:0] play_duration_ms;
    logic        serial_valid;
    logic [7:0]  serial_char;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic execute;   // apply the latched item and load the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;  // opcode of the latched item
  } sts_t;

endpackage

// ===== src/pts_ctrl.sv =====
// Controller: accepts items and sequences the capture and execute steps.
module pts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output pts_pkg::cmd_t cmd,
  input  pts_pkg::sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Each executed item yields exactly one result strobe, in the following cycle
  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> out_valid_r)
    else $error("execute without result strobe");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe while busy");
  a_exec_op: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> $stable(sts.op))
    else $error("latched opcode changed across execute");

endmodule

// ===== src/pts_dp.sv =====
// Datapath: message ring with byte store, tone ring, and the result register.
module pts_dp #(
  parameter int MSG_SLOTS  = 8,
  parameter int MSG_BYTES  = 128,
  parameter int TONE_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pts_pkg::in_t   in_item,
  input  pts_pkg::cmd_t  cmd,
  output pts_pkg::sts_t  sts,
  output pts_pkg::out_t  out_item
);

  localparam int SW    = $clog2(MSG_SLOTS);
  localparam int OW    = $clog2(MSG_BYTES);
  localparam int TW    = $clog2(TONE_SLOTS);
  localparam int DEPTH = MSG_SLOTS * MSG_BYTES;
  localparam int AW    = $clog2(DEPTH);

  // Latched item and result
  pts_pkg::in_t  item_r;
  pts_pkg::out_t out_r, out_nxt;

  // Message ring
  logic [7:0]    msg_mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          full_r, full_nxt;
  logic [OW-1:0] rd_off_r, rd_off_nxt, wr_off_r, wr_off_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  // Tone ring
  logic [15:0]   tone_freq_r [TONE_SLOTS];
  logic [15:0]   tone_dur_r  [TONE_SLOTS];
  logic          tone_vld_r  [TONE_SLOTS];
  logic [TW-1:0] th_r, th_nxt, tt_r, tt_nxt;
  logic          tfull_r, tfull_nxt;
  logic          tone_push, tone_pop;

  // Helpers
  logic [SW-1:0] tail_inc, head_inc;
  logic [TW-1:0] tt_inc, th_inc;
  logic [OW-1:0] eff_off;
  logic [7:0]    c;
  logic          msg_avail;

  assign sts.op   = item_r.op;
  assign out_item = out_r;
  assign c        = item_r.text_char;

  assign tail_inc = (tail_r == SW'(MSG_SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == SW'(MSG_SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tt_inc   = (tt_r == TW'(TONE_SLOTS - 1)) ? '0 : tt_r + 1'b1;
  assign th_inc   = (th_r == TW'(TONE_SLOTS - 1)) ? '0 : th_r + 1'b1;
  assign eff_off  = (mode_r == pts_pkg::MODE_IDLE) ? '0 : wr_off_r;
  assign msg_avail = (head_r != tail_r) || full_r;

  // Byte store read address follows the head pointer every cycle
  assign raddr = AW'(head_r) * AW'(MSG_BYTES) + AW'(rd_off_r);

  // Item execution
  always_comb begin
    out_nxt    = '0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    full_nxt   = full_r;
    rd_off_nxt = rd_off_r;
    wr_off_nxt = wr_off_r;
    mode_nxt   = mode_r;
    th_nxt     = th_r;
    tt_nxt     = tt_r;
    tfull_nxt  = tfull_r;
    tone_push  = 1'b0;
    tone_pop   = 1'b0;
    we         = 1'b0;
    waddr      = AW'(tail_r) * AW'(MSG_BYTES) + AW'(eff_off);
    wdata      = c;
    if (cmd.execute) begin
      case (item_r.op)
        pts_pkg::OP_TEXT: begin
          if (mode_r == pts_pkg::MODE_DROPPING) begin
            // refused message: swallow through its terminator
            if (c == 8'd0) mode_nxt = pts_pkg::MODE_IDLE;
          end else if (mode_r == pts_pkg::MODE_IDLE && full_r) begin
            mode_nxt = (c == 8'd0) ? pts_pkg::MODE_IDLE : pts_pkg::MODE_DROPPING;
          end else begin
            out_nxt.accepted = 1'b1;
            if (c != 8'd0) begin
              mode_nxt   = pts_pkg::MODE_WRITING;
              wr_off_nxt = eff_off;
              if (eff_off < OW'(MSG_BYTES - 1)) begin
                we         = 1'b1;
                wr_off_nxt = eff_off + 1'b1;
              end
            end else begin
              // terminator closes the message and queues the slot
              we         = 1'b1;
              tail_nxt   = tail_inc;
              if (tail_inc == head_r) full_nxt = 1'b1;
              wr_off_nxt = '0;
              mode_nxt   = pts_pkg::MODE_IDLE;
            end
          end
        end
        pts_pkg::OP_TONE: begin
          if (!tfull_r) begin
            out_nxt.accepted = 1'b1;
            tone_push        = 1'b1;
            tt_nxt           = tt_inc;
            if (tt_inc == th_r) tfull_nxt = 1'b1;
          end
        end
        pts_pkg::OP_TICK: begin
          if (tone_vld_r[th_r]) begin
            out_nxt.tone_play        = 1'b1;
            out_nxt.play_frequency   = tone_freq_r[th_r];
            out_nxt.play_duration_ms = tone_dur_r[th_r];
            tone_pop                 = 1'b1;
            th_nxt                   = th_inc;
            tfull_nxt                = 1'b0;
          end
          if (msg_avail) begin
            if (rd_data_r != 8'd0 && rd_off_r < OW'(MSG_BYTES - 1)) begin
              out_nxt.serial_valid = 1'b1;
              out_nxt.serial_char  = rd_data_r;
              rd_off_nxt           = rd_off_r + 1'b1;
            end else begin
              // end of message: free the slot
              head_nxt   = head_inc;
              rd_off_nxt = '0;
              full_nxt   = 1'b0;
            end
          end
        end
        default: begin
          out_nxt = '0;
        end
      endcase
    end
  end

  // Byte store
  always_ff @(posedge clk) begin
    if (we) msg_mem[waddr] <= wdata;
    rd_data_r <= msg_mem[raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.execute) out_r <= out_nxt;
    if (tone_push) begin
      tone_freq_r[tt_r] <= item_r.tone_frequency;
      tone_dur_r[tt_r]  <= item_r.tone_duration_ms;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      full_r   <= 1'b0;
      rd_off_r <= '0;
      wr_off_r <= '0;
      mode_r   <= pts_pkg::MODE_IDLE;
      th_r     <= '0;
      tt_r     <= '0;
      tfull_r  <= 1'b0;
      for (int i = 0; i < TONE_SLOTS; i++) tone_vld_r[i] <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      full_r   <= full_nxt;
      rd_off_r <= rd_off_nxt;
      wr_off_r <= wr_off_nxt;
      mode_r   <= mode_nxt;
      th_r     <= th_nxt;
      tt_r     <= tt_nxt;
      tfull_r  <= tfull_nxt;
      if (tone_push) tone_vld_r[tt_r] <= 1'b1;
      if (tone_pop)  tone_vld_r[th_r] <= 1'b0;
    end
  end

  a_msg_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> head_r == tail_r)
    else $error("message ring full with pointers apart");
  a_tone_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tone_vld_r[th_r] == ((th_r != tt_r) || tfull_r))
    else $error("tone head valid bit disagrees with ring pointers");
  a_tone_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    tfull_r |-> th_r == tt_r)
    else $error("tone ring full with pointers apart");

endmodule

// ===== src/print_and_tone_spooler_unit.sv =====
// Top level of the print and tone spooler.
//
// Command channel: drive in_item and raise start; the item is taken at a
// rising edge where start is high and busy is low. Opcodes are text
// character, tone enqueue and service tick (see the package).
// Result channel: out_valid is high for exactly one cycle with out_item,
// which carries one result for every item taken. The receiver cannot stall.
// Timing: a taken item is latched, then executed in the following cycle, and
// its result is registered and shown with out_valid. busy is high during
// the execute cycle only, so a new item can be taken in the cycle where the
// previous result is shown, but not while the previous item executes. The
// message byte store has a registered read port, addressed by the head slot
// and read offset on every edge.
// Reset (rst_n low, synchronous) empties both rings and clears the tone
// valid bits; the message byte store is not cleared, since only bytes of
// complete messages are ever read.
module print_and_tone_spooler_unit #(
  parameter int MSG_SLOTS  = 8,
  parameter int MSG_BYTES  = 128,
  parameter int TONE_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pts_pkg::in_t  in_item,
  output logic          out_valid,
  output pts_pkg::out_t out_item
);

  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pts_dp #(
    .MSG_SLOTS  (MSG_SLOTS),
    .MSG_BYTES  (MSG_BYTES),
    .TONE_SLOTS (TONE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
